// ===== rtl/stsaq_pkg.sv =====
// Shared types, codes and constants of the segment tree range-sum block.
package stsaq_pkg;

    localparam int ARRAY_SIZE_DEF = 1024;
    localparam int SIZE_W         = 11;
    localparam int SIZE_RESET     = 1024;
    localparam int POS_W          = 10;
    localparam int VAL_W          = 32;
    localparam int SUM_W          = 48;
    localparam int ST_W           = 2;
    localparam int KIND_W         = 2;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic [ST_W-1:0] ST_ASSIGNED = 2'd0;
    localparam logic [ST_W-1:0] ST_ANSWERED = 2'd1;
    localparam logic [ST_W-1:0] ST_IGNORED  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IGNORE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd3;

    localparam logic REG_SIZE = 1'b0;

    typedef struct packed {
        logic                    func;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        low_end;
        logic [POS_W-1:0]        high_end;
    } t_in;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [ST_W-1:0]         status;
    } t_out;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        lo;
        logic [POS_W-1:0]        hi;
    } t_cmd;

endpackage

// ===== rtl/stsaq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stsaq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/stsaq_front.sv =====
// Front end: accepts items, clips and classifies them, and queues commands.
module stsaq_front
    import stsaq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_in               i_data,
    output logic              o_stall,
    input  logic [SIZE_W-1:0] i_size,
    input  logic              i_busy,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);
    t_cmd        r_q [2];
    logic        r_wp, n_wp;
    logic        r_rp, n_rp;
    logic [1:0]  r_cnt, n_cnt;
    logic        push;
    t_cmd        cmd;
    logic [SIZE_W-1:0] last_pos;
    logic [SIZE_W-1:0] hi_clip;

    always_comb begin
        last_pos  = i_size - SIZE_W'(1);
        hi_clip   = ({1'b0, i_data.high_end} > last_pos) ? last_pos : {1'b0, i_data.high_end};
        cmd.value = i_data.value;
        cmd.hi    = hi_clip[POS_W-1:0];
        if (i_data.func == FUNC_ASSIGN) begin
            cmd.lo   = i_data.position;
            cmd.kind = ({1'b0, i_data.position} >= i_size) ? KIND_IGNORE : KIND_ASSIGN;
        end else begin
            cmd.lo   = i_data.low_end;
            cmd.kind = (({1'b0, i_data.low_end} >= i_size) ||
                        ({1'b0, i_data.low_end} > hi_clip)) ? KIND_EMPTY : KIND_QUERY;
        end
    end

    assign o_stall     = (r_cnt == 2'd2) || i_busy;
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = i_cmd_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end
endmodule

// ===== rtl/stsaq_back.sv =====
// Back end: walks the sum tree in memory for assigns and queries, drives results.
module stsaq_back
    import stsaq_pkg::*;
#(
    parameter int ARRAY_SIZE = ARRAY_SIZE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clear,
    output logic o_busy,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);
    localparam int LEAVES = 1 << $clog2(ARRAY_SIZE);
    localparam int DEPTH  = 2 * LEAVES;
    localparam int AW     = $clog2(DEPTH);
    localparam int NW     = AW + 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_QRY  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [AW-1:0]           r_clr, n_clr;
    logic [AW-1:0]           r_node, n_node;
    logic [NW-1:0]           r_l, n_l, r_r, n_r;
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic                    r_pend, n_pend;
    logic [ST_W-1:0]         r_st, n_st;
    logic                    r_out_vld, n_out_vld;
    t_out                    r_out, n_out;

    logic                    we;
    logic [AW-1:0]           waddr, raddr, leaf, parent;
    logic signed [SUM_W-1:0] wdata, rdata, sval, usum;
    logic                    out_free;

    stsaq_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign out_free = !r_out_vld || !i_stall;
    assign o_busy   = (r_state == S_CLR);
    assign o_valid  = r_out_vld;
    assign o_data   = r_out;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_node    = r_node;
        n_l       = r_l;
        n_r       = r_r;
        n_st      = r_st;
        n_pend    = 1'b0;
        n_acc     = r_pend ? r_acc + rdata : r_acc;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_stall;
        we        = 1'b0;
        waddr     = r_clr;
        wdata     = '0;
        raddr     = '0;
        o_cmd_pop = 1'b0;
        sval      = {{(SUM_W-VAL_W){i_cmd.value[VAL_W-1]}}, i_cmd.value};
        leaf      = AW'(LEAVES) + AW'(i_cmd.lo);
        usum      = r_acc + rdata;
        parent    = r_node >> 1;
        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_acc     = '0;
                    case (i_cmd.kind)
                        KIND_ASSIGN: begin
                            we      = 1'b1;
                            waddr   = leaf;
                            wdata   = sval;
                            raddr   = leaf ^ AW'(1);
                            n_node  = leaf;
                            n_acc   = sval;
                            n_st    = ST_ASSIGNED;
                            n_state = S_UP;
                        end
                        KIND_QUERY: begin
                            n_l     = NW'(LEAVES) + NW'(i_cmd.lo);
                            n_r     = NW'(LEAVES) + NW'(i_cmd.hi) + NW'(1);
                            n_st    = ST_ANSWERED;
                            n_state = S_QRY;
                        end
                        KIND_IGNORE: begin
                            n_st    = ST_IGNORED;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_st    = ST_ANSWERED;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP: begin
                we     = 1'b1;
                waddr  = parent;
                wdata  = usum;
                n_acc  = usum;
                n_node = parent;
                raddr  = parent ^ AW'(1);
                if (parent == AW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_QRY: begin
                if (r_l < r_r) begin
                    if (r_l[0]) begin
                        raddr  = r_l[AW-1:0];
                        n_l    = r_l + NW'(1);
                        n_pend = 1'b1;
                    end else if (r_r[0]) begin
                        n_r    = r_r - NW'(1);
                        raddr  = n_r[AW-1:0];
                        n_pend = 1'b1;
                    end else begin
                        n_l = r_l >> 1;
                        n_r = r_r >> 1;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.sum    = (r_st == ST_ANSWERED) ? r_acc : '0;
                    n_out.status = r_st;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_clear) begin
            n_state = S_CLR;
            n_clr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
        r_node <= n_node;
        r_l    <= n_l;
        r_r    <= n_r;
        r_acc  <= n_acc;
        r_st   <= n_st;
        r_out  <= n_out;
    end

    a_pend_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state) == S_QRY)
        else $error("read data pending outside a query walk");

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_cmd_pop)
        else $error("command taken during clearing pass");

    a_up_above_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UP |-> r_node > AW'(1))
        else $error("update walk passed the root");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> r_out_vld)
        else $error("finished item not presented");
endmodule

// ===== rtl/segment_tree_sum_assign_query.sv =====
// Top level of the segment tree range-sum block with point assign.
// Assign: walks from the leaf up to the root, P the leaf count (ARRAY_SIZE rounded up to a power of two).
// Query: walks the range bounds up the tree; at most one tree-memory read per cycle sets the pace.
// One item is carried out at a time; a two-entry command queue buffers the next ones.
// Reset and every write of size_in_use start a clearing pass that zeroes all 2*P entries
// of the tree memory (2048 by default); no item is accepted during that pass.
module segment_tree_sum_assign_query
    import stsaq_pkg::*;
#(
    parameter int ARRAY_SIZE = ARRAY_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Item channel.
    input  logic              i_valid,
    input  t_in               i_data,
    output logic              o_stall,
    // Result channel.
    output logic              o_valid,
    output t_out              o_data,
    input  logic              i_stall,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    // The size register saturates into 1..ARRAY_SIZE as it is written.
    localparam int SIZE_INIT = (SIZE_RESET > ARRAY_SIZE) ? ARRAY_SIZE : SIZE_RESET;

    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] wr_raw;
    logic              cfg_wr;
    logic              size_wr;
    logic              busy;
    logic              cmd_valid;
    logic              cmd_pop;
    t_cmd              cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    // Only word address 0 (byte addresses 0 to 3) holds a register; other addresses are ignored.
    assign size_wr = cfg_wr && (paddr[ADDR_W-1:2] == REG_SIZE);
    assign wr_raw  = pwdata[SIZE_W-1:0];
    assign prdata  = (paddr[ADDR_W-1:2] == REG_SIZE) ? DATA_W'(r_size) : '0;

    always_comb begin
        n_size = r_size;
        if (size_wr) begin
            if (wr_raw == '0) begin
                n_size = SIZE_W'(1);
            end else if (32'(wr_raw) > 32'(ARRAY_SIZE)) begin
                n_size = SIZE_W'(ARRAY_SIZE);
            end else begin
                n_size = wr_raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(SIZE_INIT);
        end else begin
            r_size <= n_size;
        end
    end

    // The front clips query ends against the size and flags positions out of range.
    stsaq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .i_size     (r_size),
        .i_busy     (busy),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    // The back walks a bottom-up sum tree held in one memory and owns the result register.
    stsaq_back #(.ARRAY_SIZE(ARRAY_SIZE)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (size_wr),
        .o_busy     (busy),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );
endmodule

// ===== dv/tb_segment_tree_sum_assign_query.sv =====
// Self-checking testbench for the segment tree range-sum block with point assign.
module tb_segment_tree_sum_assign_query;
    import stsaq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it; a write there must be ignored.
    localparam int REG_UNUSED = 1;
    localparam int CYCLE_LIMIT = 2_000_000;
    // Cycles allowed after the last result before idling or ending.
    localparam int SETTLE_CYCLES = 60;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    t_in               i_data = '0;
    logic              o_stall;
    logic              o_valid;
    t_out              o_data;
    logic              i_stall = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    segment_tree_sum_assign_query dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the array that the tree covers. A plain array is enough here:
    // every node sum is the sum of its leaves, and no 48-bit sum can overflow.
    longint      leaf_values [ARRAY_SIZE_DEF];
    int unsigned tree_size = SIZE_RESET;
    t_out        pending_results [$];
    int          error_count = 0;
    int          cycle_count = 0;

    // Idle controls, in percent, and the length of a long receiver hold-off.
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    // Applies one accepted beat to the shadow array and returns its result.
    function automatic t_out apply_item(input t_in item);
        t_out        res;
        int unsigned lo;
        int unsigned hi;
        longint      total;
        res = '0;
        lo = item.low_end;
        hi = item.high_end;
        total = 0;
        if (item.func == FUNC_ASSIGN) begin
            if (item.position >= tree_size) begin
                res.status = ST_IGNORED;
            end else begin
                leaf_values[item.position] = longint'(item.value);
                res.status = ST_ASSIGNED;
            end
        end else begin
            if (hi > tree_size - 1) hi = tree_size - 1;
            if (lo < tree_size && lo <= hi) begin
                for (int unsigned k = lo; k <= hi; k++) total += leaf_values[k];
            end
            res.sum = total[SUM_W-1:0];
            res.status = ST_ANSWERED;
        end
        return res;
    endfunction

    // Mirrors a register write; only size_in_use exists, and writing it clears the tree.
    function automatic void apply_register(input int index, input logic [DATA_W-1:0] data);
        int unsigned n;
        if (index != int'(REG_SIZE)) return;
        n = data[SIZE_W-1:0];
        if (n == 0) n = 1;
        if (n > ARRAY_SIZE_DEF) n = ARRAY_SIZE_DEF;
        tree_size = n;
        foreach (leaf_values[k]) leaf_values[k] = 0;
    endfunction

    // Offers one beat, with random idle cycles first, and waits until it is taken.
    // Valid stays high afterward so that back-to-back beats need no extra edge.
    task automatic send_item(input t_in item);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.insert(pending_results.size(), apply_item(item));
    endtask

    // Drops valid and waits until every result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One write on the configuration port: setup cycle, then access cycle.
    task automatic write_register(input int index, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * index);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register(index, data);
    endtask

    function automatic t_in make_assign(input int pos, input logic [VAL_W-1:0] val);
        t_in item;
        item = '0;
        item.func = FUNC_ASSIGN;
        item.position = pos[POS_W-1:0];
        item.value = val;
        item.low_end = POS_W'($urandom);
        item.high_end = POS_W'($urandom);
        return item;
    endfunction

    function automatic t_in make_query(input int lo, input int hi);
        t_in item;
        item = '0;
        item.func = FUNC_QUERY;
        item.position = POS_W'($urandom);
        item.value = $urandom;
        item.low_end = lo[POS_W-1:0];
        item.high_end = hi[POS_W-1:0];
        return item;
    endfunction

    // Random beat: mostly in-range positions and ranges, with extremes mixed in.
    function automatic t_in random_item();
        logic [VAL_W-1:0] val;
        int               pos;
        int               lo;
        int               hi;
        case ($urandom_range(3))
            0: val = 32'h7FFF_FFFF;
            1: val = 32'h8000_0000;
            default: val = $urandom;
        endcase
        pos = ($urandom_range(99) < 85) ? $urandom_range(tree_size - 1) : $urandom_range(1023);
        if ($urandom_range(2) == 0) begin
            lo = $urandom_range(1023);
            hi = $urandom_range(1023);
        end else begin
            lo = $urandom_range(tree_size - 1);
            hi = $urandom_range(tree_size - 1);
            if (lo > hi && $urandom_range(3) != 0) begin
                int swap;
                swap = lo;
                lo = hi;
                hi = swap;
            end
        end
        return $urandom_range(1) ? make_query(lo, hi) : make_assign(pos, val);
    endfunction

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) send_item(random_item());
        drain();
    endtask

    // Extremes of the fields and every special case, at full and tiny sizes.
    task automatic test_directed();
        send_item(make_query(0, 1023));
        send_item(make_assign(0, 32'h7FFF_FFFF));
        send_item(make_assign(1023, 32'h8000_0000));
        send_item(make_assign(5, 32'hFFFF_FFFF));
        send_item(make_assign(512, 32'h5555_5555));
        send_item(make_assign(341, 32'hAAAA_AAAA));
        send_item(make_query(0, 1023));
        send_item(make_query(0, 0));
        send_item(make_query(1023, 1023));
        send_item(make_query(10, 3));
        send_item(make_query(5, 5));
        drain();
        write_register(REG_SIZE, 7);
        send_item(make_assign(7, 32'h1234_5678));
        send_item(make_assign(1023, 32'h1));
        send_item(make_assign(6, 32'h8000_0000));
        send_item(make_assign(0, 32'h7FFF_FFFF));
        send_item(make_query(3, 1023));
        send_item(make_query(7, 9));
        send_item(make_query(0, 6));
        drain();
        // Zero is taken as one position.
        write_register(REG_SIZE, 0);
        send_item(make_assign(0, 32'hDEAD_BEEF));
        send_item(make_assign(1, 32'h5));
        send_item(make_query(0, 1023));
        send_item(make_query(1, 1));
        drain();
        // A write to a missing register leaves size and contents alone.
        write_register(REG_UNUSED, 3);
        send_item(make_query(0, 0));
        drain();
    endtask

    task automatic test_no_idle();
        sender_idle_pct = 0;
        stall_pct = 0;
        write_register(REG_SIZE, 32'hFFFF_F800 | 32'd1024);
        run_random(300);
    endtask

    task automatic test_sender_idle();
        sender_idle_pct = 70;
        stall_pct = 0;
        write_register(REG_SIZE, 100);
        run_random(250);
    endtask

    task automatic test_receiver_stall();
        sender_idle_pct = 0;
        stall_pct = 70;
        // Above the array size, saturates to the full array.
        write_register(REG_SIZE, 2047);
        run_random(250);
    endtask

    task automatic test_light_idle();
        sender_idle_pct = 7;
        stall_pct = 7;
        write_register(REG_SIZE, 2);
        run_random(100);
        write_register(REG_SIZE, 13);
        run_random(100);
    endtask

    // The receiver holds off long enough that the command queue fills and
    // the block stalls its input while the sender keeps offering beats.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct = 0;
        write_register(REG_SIZE, 1024);
        hold_request = 400;
        run_random(80);
    endtask

    // Receiver stall: a long hold-off when requested, otherwise random.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Each result beat is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result sum=%0d status=%0d",
                                 o_data.sum, o_data.status));
            end else begin
                want = pending_results.pop_front();
                if (o_data.sum !== want.sum)
                    report($sformatf("sum %0d, expected %0d", o_data.sum, want.sum));
                if (o_data.status !== want.status)
                    report($sformatf("status %0d, expected %0d",
                                     o_data.status, want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        foreach (leaf_values[k]) leaf_values[k] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_light_idle();
        test_backpressure();
        if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stsaq_pkg.sv
rtl/stsaq_ram.sv
rtl/stsaq_front.sv
rtl/stsaq_back.sv
rtl/segment_tree_sum_assign_query.sv
dv/tb_segment_tree_sum_assign_query.sv
